// File: src/u2r_pkg.sv
// Shared constants, types and the channel clamp for the UYVY to RGB888 converter.
// No dependencies; imported by the channel interfaces and the top level.
package u2r_pkg;

  localparam int unsigned SAMPLE_W = 8;   // width of every sample and channel
  localparam int unsigned OFS_W    = 9;   // offset-removed sample, signed
  localparam int unsigned PROD_W   = 19;  // coefficient products, signed
  localparam int unsigned SUM_W    = 20;  // channel sums before the shift, signed
  localparam int unsigned LANES    = 2;   // pixels per item

  localparam logic [OFS_W-1:0] LUMA_OFS   = 9'd16;
  localparam logic [OFS_W-1:0] CHROMA_OFS = 9'd128;

  localparam logic signed [PROD_W-1:0] K_Y    = 19'sd298;
  localparam logic signed [PROD_W-1:0] K_R_CR = 19'sd409;
  localparam logic signed [PROD_W-1:0] K_G_CB = 19'sd100;
  localparam logic signed [PROD_W-1:0] K_G_CR = 19'sd208;
  localparam logic signed [PROD_W-1:0] K_B_CB = 19'sd516;
  localparam logic signed [SUM_W-1:0]  K_ROUND = 20'sd128;

  localparam logic [SAMPLE_W-1:0] CH_MAX = 8'd255;
  localparam logic [SAMPLE_W-1:0] CH_MIN = 8'd0;

  typedef logic signed [OFS_W-1:0]  ofs_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [SAMPLE_W-1:0]      chan_t;

  // Floor shift by 8, then saturate to 0..255.
  function automatic chan_t clamp_chan(sum_t sum);
    chan_t res;
    if (sum[SUM_W-1]) begin
      res = CH_MIN;
    end else if (sum[SUM_W-2:SAMPLE_W+8] != '0) begin
      res = CH_MAX;
    end else begin
      res = sum[SAMPLE_W+7:8];
    end
    return res;
  endfunction

endpackage

// File: src/u2r_pair_if.sv
// Input channel: one packed 4:2:2 pair (Cb, Y0, Cr, Y1) plus end-of-frame mark.
// Depends on u2r_pkg for the sample width.
interface u2r_pair_if import u2r_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] cb_sample;
  logic [SAMPLE_W-1:0] luma_first;
  logic [SAMPLE_W-1:0] cr_sample;
  logic [SAMPLE_W-1:0] luma_second;
  logic                frame_end_in;

  modport source (output valid, cb_sample, luma_first, cr_sample, luma_second,
                  frame_end_in, input ready);
  modport sink   (input valid, cb_sample, luma_first, cr_sample, luma_second,
                  frame_end_in, output ready);
endinterface

// File: src/u2r_pix_if.sv
// Output channel: two RGB888 pixels plus the end-of-frame mark.
// Depends on u2r_pkg for the channel width.
interface u2r_pix_if import u2r_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_first;
  logic [SAMPLE_W-1:0] green_first;
  logic [SAMPLE_W-1:0] blue_first;
  logic [SAMPLE_W-1:0] red_second;
  logic [SAMPLE_W-1:0] green_second;
  logic [SAMPLE_W-1:0] blue_second;
  logic                frame_end_out;

  modport source (output valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, frame_end_out, input ready);
  modport sink   (input valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, frame_end_out, output ready);
endinterface

// File: src/uyvy_to_rgb888_converter.sv
// UYVY 4:2:2 pair to two RGB888 pixels, integer BT.601, four-stage pipeline.
// Depends on u2r_pkg, u2r_pair_if and u2r_pix_if.

// Accepts one pixel pair per clock unless back-pressure holds the input, and
// passes each pair through the stage 1 to 3 and output registers. The
// stages are: offset removal, coefficient multiplies (one 19-bit multiply
// per term), channel sums with rounding, and shift/clamp into the output
// register. Each stage holds its own valid bit and advances when the stage
// after it is empty or moving, so a stall at the output fills the bubbles
// before back-pressure reaches the input; up to four items are held in
// flight. The end-of-frame mark rides along with its pair unchanged.
module uyvy_to_rgb888_converter import u2r_pkg::*; (
  input logic       clk,
  input logic       rst,
  u2r_pair_if.sink  pair_in,
  u2r_pix_if.source pix_out
);

  // stage valid bits and advance enables
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // stage 1: offset-removed samples
  ofs_t y_s1 [LANES];
  ofs_t cb_s1, cr_s1;
  logic fe_s1;

  // stage 2: products
  prod_t py_s2 [LANES];
  prod_t prcr_s2, pgcb_s2, pgcr_s2, pbcb_s2;
  logic  fe_s2;

  // stage 3: channel sums
  sum_t r_s3 [LANES];
  sum_t g_s3 [LANES];
  sum_t b_s3 [LANES];
  logic fe_s3;

  assign adv4 = !v4 || pix_out.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pair_in.ready = adv1;
  assign pix_out.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= pair_in.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      y_s1[0] <= ofs_t'({1'b0, pair_in.luma_first} - LUMA_OFS);
      y_s1[1] <= ofs_t'({1'b0, pair_in.luma_second} - LUMA_OFS);
      cb_s1   <= ofs_t'({1'b0, pair_in.cb_sample} - CHROMA_OFS);
      cr_s1   <= ofs_t'({1'b0, pair_in.cr_sample} - CHROMA_OFS);
      fe_s1   <= pair_in.frame_end_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int j = 0; j < LANES; j++) begin
        py_s2[j] <= prod_t'(y_s1[j]) * K_Y;
      end
      prcr_s2 <= prod_t'(cr_s1) * K_R_CR;
      pgcb_s2 <= prod_t'(cb_s1) * K_G_CB;
      pgcr_s2 <= prod_t'(cr_s1) * K_G_CR;
      pbcb_s2 <= prod_t'(cb_s1) * K_B_CB;
      fe_s2   <= fe_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      for (int j = 0; j < LANES; j++) begin
        r_s3[j] <= sum_t'(py_s2[j]) + sum_t'(prcr_s2) + K_ROUND;
        g_s3[j] <= sum_t'(py_s2[j]) - sum_t'(pgcb_s2) - sum_t'(pgcr_s2) + K_ROUND;
        b_s3[j] <= sum_t'(py_s2[j]) + sum_t'(pbcb_s2) + K_ROUND;
      end
      fe_s3 <= fe_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      pix_out.red_first     <= clamp_chan(r_s3[0]);
      pix_out.green_first   <= clamp_chan(g_s3[0]);
      pix_out.blue_first    <= clamp_chan(b_s3[0]);
      pix_out.red_second    <= clamp_chan(r_s3[1]);
      pix_out.green_second  <= clamp_chan(g_s3[1]);
      pix_out.blue_second   <= clamp_chan(b_s3[1]);
      pix_out.frame_end_out <= fe_s3;
    end
  end

  // back-pressure reaches the input only once every stage is full
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !pair_in.ready |-> (v1 && v2 && v3 && v4))
    else $error("input stalled with a free pipeline stage");

  // an empty output register never stalls the input
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !v4 |-> pair_in.ready)
    else $error("input not ready while output register empty");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!v1 && !v2 && !v3 && !v4))
    else $error("stage valid set after reset");

  // a negative first-pixel red sum lands in the output as zero
  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    (v3 && adv4 && r_s3[0][SUM_W-1]) |=> (pix_out.red_first == CH_MIN))
    else $error("negative red sum not clamped to zero");

  // an item in stage 3 moves out unless the output is stalled
  a_stage3_moves: assert property (@(posedge clk) disable iff (rst)
    (v3 && adv4) |=> v4)
    else $error("stage 3 item lost");

endmodule

// File: sim/uyvy_to_rgb888_converter_tb.sv
// Self-checking testbench for uyvy_to_rgb888_converter: random and directed pixel pairs,
// random idling on both sides and a long output stall. Depends on u2r_pkg and the interfaces.
module uyvy_to_rgb888_converter_tb;
  import u2r_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_PAIRS = 1100;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    chan_t cb, y0, cr, y1;
    logic  fe;
  } pair_t;

  typedef struct {
    chan_t red_first, green_first, blue_first;
    chan_t red_second, green_second, blue_second;
    logic  frame_end_out;
  } pixels_t;

  class pixel_scoreboard;
    pixels_t pending[$];
    int      errors = 0;

    // floor shift, then saturate
    function chan_t sat_channel(int sum);
      int q;
      q = sum >>> 8;
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
    endfunction

    function void convert(int y, int u, int v, output chan_t r, output chan_t g,
                          output chan_t b);
      int c;
      c = 298 * y + 128;
      r = sat_channel(c + 409 * v);
      g = sat_channel(c - 100 * u - 208 * v);
      b = sat_channel(c + 516 * u);
    endfunction

    function void note_pair(pair_t p);
      pixels_t e;
      int u, v;
      u = int'(p.cb) - 128;
      v = int'(p.cr) - 128;
      convert(int'(p.y0) - 16, u, v, e.red_first, e.green_first, e.blue_first);
      convert(int'(p.y1) - 16, u, v, e.red_second, e.green_second, e.blue_second);
      e.frame_end_out = p.fe;
      pending.push_back(e);
    endfunction

    function void compare_field(string name, chan_t exp_val, chan_t act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_pixels(pixels_t got);
      pixels_t e;
      if (pending.size() == 0) begin
        $error("output item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      compare_field("red_first", e.red_first, got.red_first);
      compare_field("green_first", e.green_first, got.green_first);
      compare_field("blue_first", e.blue_first, got.blue_first);
      compare_field("red_second", e.red_second, got.red_second);
      compare_field("green_second", e.green_second, got.green_second);
      compare_field("blue_second", e.blue_second, got.blue_second);
      compare_field("frame_end_out", chan_t'(e.frame_end_out), chan_t'(got.frame_end_out));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  u2r_pair_if pair_if ();
  u2r_pix_if  pix_if ();

  uyvy_to_rgb888_converter DUT (
    .clk     (clk),
    .rst     (rst),
    .pair_in (pair_if),
    .pix_out (pix_if)
  );

  pixel_scoreboard board = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_left  = 0;
  int unsigned cycles      = 0;
  logic        stall_req   = 1'b0;
  logic        stall_done  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: check accepted items, then pick next ready.
  always @(posedge clk) begin
    pixels_t got;
    if (!rst && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
      got.red_first     = pix_if.red_first;
      got.green_first   = pix_if.green_first;
      got.blue_first    = pix_if.blue_first;
      got.red_second    = pix_if.red_second;
      got.green_second  = pix_if.green_second;
      got.blue_second   = pix_if.blue_second;
      got.frame_end_out = pix_if.frame_end_out;
      board.check_pixels(got);
    end
    if (stall_req && !stall_done) begin
      stall_left = STALL_CYCLES;
      stall_done <= 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      pix_if.ready <= 1'b0;
    end else begin
      pix_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic pair_t make_pair(chan_t cb, chan_t y0, chan_t cr, chan_t y1, logic fe);
    pair_t p;
    p.cb = cb;
    p.y0 = y0;
    p.cr = cr;
    p.y1 = y1;
    p.fe = fe;
    return p;
  endfunction

  // mostly full range, some nominal video levels
  function automatic pair_t random_pair();
    pair_t p;
    if ($urandom_range(3) != 0) begin
      p = make_pair(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom),
                    chan_t'($urandom), 1'b0);
    end else begin
      p = make_pair(chan_t'($urandom_range(240, 16)), chan_t'($urandom_range(235, 16)),
                    chan_t'($urandom_range(240, 16)), chan_t'($urandom_range(235, 16)),
                    1'b0);
    end
    p.fe = ($urandom_range(15) == 0);
    return p;
  endfunction

  // Called right after the clock rises; returns after the item is accepted.
  task automatic offer_pair(pair_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk);
    end
    pair_if.valid        <= 1'b1;
    pair_if.cb_sample    <= p.cb;
    pair_if.luma_first   <= p.y0;
    pair_if.cr_sample    <= p.cr;
    pair_if.luma_second  <= p.y1;
    pair_if.frame_end_in <= p.fe;
    do @(posedge clk); while (pair_if.ready !== 1'b1);
    board.note_pair(p);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    rst                  <= 1'b1;
    pair_if.valid        <= 1'b0;
    pair_if.cb_sample    <= '0;
    pair_if.luma_first   <= '0;
    pair_if.cr_sample    <= '0;
    pair_if.luma_second  <= '0;
    pair_if.frame_end_in <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct <= 27;
    rx_idle_pct <= 68;
    @(posedge clk);

    // extremes, black/white, saturating chroma corners
    offer_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    offer_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    offer_pair(make_pair(8'd128, 8'd16, 8'd128, 8'd16, 1'b0));
    offer_pair(make_pair(8'd128, 8'd235, 8'd128, 8'd235, 1'b0));
    offer_pair(make_pair(8'd128, 8'd0, 8'd128, 8'd255, 1'b0));
    offer_pair(make_pair(8'd255, 8'd128, 8'd255, 8'd128, 1'b0));
    offer_pair(make_pair(8'd0, 8'd128, 8'd0, 8'd128, 1'b1));
    offer_pair(make_pair(8'd255, 8'd128, 8'd0, 8'd128, 1'b0));
    offer_pair(make_pair(8'd0, 8'd128, 8'd255, 8'd128, 1'b0));
    offer_pair(make_pair(8'd16, 8'd16, 8'd240, 8'd235, 1'b0));
    offer_pair(make_pair(8'd240, 8'd235, 8'd16, 8'd16, 1'b0));
    offer_pair(make_pair(8'd255, 8'd0, 8'd255, 8'd0, 1'b0));
    offer_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    offer_pair(make_pair(8'd170, 8'd85, 8'd85, 8'd170, 1'b1));
    offer_pair(make_pair(8'd85, 8'd170, 8'd170, 8'd85, 1'b0));
    offer_pair(make_pair(8'd128, 8'd128, 8'd128, 8'd128, 1'b0));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct <= 27;
          rx_idle_pct <= 68;
        end
        1: begin
          tx_idle_pct <= 68;
          rx_idle_pct <= 27;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
          stall_req   <= 1'b1;  // long output hold-off while input keeps coming
        end
      endcase
      for (n = 0; n < RANDOM_PAIRS / 3; n++) begin
        offer_pair(random_pair());
      end
    end
    pair_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
